// ===== rtl/core/sae_pkg.sv =====
// shared types and constants of the suffix automaton builder
`default_nettype none
package sae_pkg;

    localparam int MAX_NODES = 4096;
    localparam int ALPHABET  = 26;
    localparam int NODE_W    = 12;
    localparam int USED_W    = NODE_W + 1;
    localparam int SYM_W     = 5;
    localparam int K_W       = SYM_W + 1;
    localparam int LEN_W     = 13;
    localparam int TOTAL_W   = 22;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = NODE_W + SYM_W;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    // datapath operation issued by the controller each cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_LEN_RD,
        OP_LEN_WR,
        OP_CLR,
        OP_W_RD,
        OP_W_CHK,
        OP_W_LINK,
        OP_LP,
        OP_LQ,
        OP_CL_LINK,
        OP_CL_LINK2,
        OP_COPY,
        OP_C_RD,
        OP_C_CHK,
        OP_C_LINK,
        OP_FIN,
        OP_DIFF,
        OP_OUT
    } op_t;

    // datapath flags seen by the controller
    typedef struct packed {
        logic in_err;
        logic init_done;
        logic clr_done;
        logic copy_done;
        logic walk_go;
        logic clone_go;
        logic clone_need;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/sae_in_if.sv =====
// input channel: node to extend from and symbol
`default_nettype none
interface sae_in_if;
    logic                            valid;
    logic                            ready;
    logic [sae_pkg::NODE_W-1:0]      from_node;
    logic [sae_pkg::SYM_W-1:0]       symbol;

    modport source (output valid, output from_node, output symbol, input ready);
    modport sink   (input valid, input from_node, input symbol, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sae_out_if.sv =====
// output channel: new node, substring count and status
`default_nettype none
interface sae_out_if;
    logic                            valid;
    logic                            ready;
    logic [sae_pkg::NODE_W-1:0]      new_node;
    logic [sae_pkg::TOTAL_W-1:0]     distinct_substrings;
    logic [sae_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output new_node, output distinct_substrings,
                    output status, input ready);
    modport sink   (input valid, input new_node, input distinct_substrings,
                    input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sae_ctrl.sv =====
// sequencing state machine of the suffix automaton builder
`default_nettype none
module sae_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sae_pkg::dp_status_t st,
    output sae_pkg::op_t             op
);

    typedef enum logic [18:0] {
        S_INIT     = 19'h00001,
        S_IDLE     = 19'h00002,
        S_LEN_RD   = 19'h00004,
        S_LEN_WR   = 19'h00008,
        S_CLR      = 19'h00010,
        S_W_RD     = 19'h00020,
        S_W_CHK    = 19'h00040,
        S_W_LINK   = 19'h00080,
        S_LP       = 19'h00100,
        S_LQ       = 19'h00200,
        S_CL_LINK  = 19'h00400,
        S_CL_LINK2 = 19'h00800,
        S_COPY     = 19'h01000,
        S_C_RD     = 19'h02000,
        S_C_CHK    = 19'h04000,
        S_C_LINK   = 19'h08000,
        S_FIN      = 19'h10000,
        S_DIFF     = 19'h20000,
        S_DONE     = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        op         = sae_pkg::OP_NONE;
        case (state_reg)
            S_INIT:
            begin
                op = sae_pkg::OP_INIT;
                if (st.init_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = sae_pkg::OP_LOAD;
                    state_next = st.in_err ? S_DONE : S_LEN_RD;
                end
            end
            S_LEN_RD:
            begin
                op         = sae_pkg::OP_LEN_RD;
                state_next = S_LEN_WR;
            end
            S_LEN_WR:
            begin
                op         = sae_pkg::OP_LEN_WR;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                op = sae_pkg::OP_CLR;
                if (st.clr_done)
                    state_next = S_W_RD;
            end
            S_W_RD:
            begin
                op         = sae_pkg::OP_W_RD;
                state_next = S_W_CHK;
            end
            S_W_CHK:
            begin
                op         = sae_pkg::OP_W_CHK;
                state_next = st.walk_go ? S_W_LINK : S_LP;
            end
            S_W_LINK:
            begin
                op         = sae_pkg::OP_W_LINK;
                state_next = S_W_RD;
            end
            S_LP:
            begin
                op         = sae_pkg::OP_LP;
                state_next = S_LQ;
            end
            S_LQ:
            begin
                op         = sae_pkg::OP_LQ;
                state_next = st.clone_need ? S_CL_LINK : S_FIN;
            end
            S_CL_LINK:
            begin
                op         = sae_pkg::OP_CL_LINK;
                state_next = S_CL_LINK2;
            end
            S_CL_LINK2:
            begin
                op         = sae_pkg::OP_CL_LINK2;
                state_next = S_COPY;
            end
            S_COPY:
            begin
                op = sae_pkg::OP_COPY;
                if (st.copy_done)
                    state_next = S_C_RD;
            end
            S_C_RD:
            begin
                op         = sae_pkg::OP_C_RD;
                state_next = S_C_CHK;
            end
            S_C_CHK:
            begin
                op         = sae_pkg::OP_C_CHK;
                state_next = st.clone_go ? S_C_LINK : S_FIN;
            end
            S_C_LINK:
            begin
                op         = sae_pkg::OP_C_LINK;
                state_next = S_C_RD;
            end
            S_FIN:
            begin
                op         = sae_pkg::OP_FIN;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                op         = sae_pkg::OP_DIFF;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!st.out_busy)
                begin
                    op         = sae_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/sae_dp.sv =====
// node tables, walk registers and result register of the suffix automaton builder
`default_nettype none
module sae_dp
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sae_pkg::op_t                        op,
    output sae_pkg::dp_status_t                      st,
    input  wire logic [sae_pkg::NODE_W-1:0]          from_node,
    input  wire logic [sae_pkg::SYM_W-1:0]           symbol,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [sae_pkg::NODE_W-1:0]               new_node,
    output logic [sae_pkg::TOTAL_W-1:0]              distinct_substrings,
    output logic [sae_pkg::STATUS_W-1:0]             status
);

    localparam int NW  = sae_pkg::NODE_W;
    localparam int SW  = sae_pkg::SYM_W;
    localparam int KW  = sae_pkg::K_W;
    localparam int LW  = sae_pkg::LEN_W;
    localparam int TW  = sae_pkg::TOTAL_W;
    localparam int UW  = sae_pkg::USED_W;
    localparam int AW  = sae_pkg::ADDR_W;
    localparam logic [KW-1:0] A_LAST  = KW'(sae_pkg::ALPHABET - 1);
    localparam logic [KW-1:0] A_COUNT = KW'(sae_pkg::ALPHABET);
    localparam logic [UW:0]   MAXN    = (UW+1)'(sae_pkg::MAX_NODES);
    localparam logic [TW-1:0] TOT_MAX = {TW{1'b1}};
    localparam int STATUS_W_T = sae_pkg::STATUS_W;

    // tables
    logic [NW-1:0]        trans_mem [0:(1<<AW)-1];
    logic signed [LW-1:0] len_mem   [0:(1<<NW)-1];
    logic [NW-1:0]        link_mem  [0:(1<<NW)-1];

    logic [NW-1:0]        trans_rdata_reg;
    logic signed [LW-1:0] len_rdata_reg;
    logic [NW-1:0]        link_rdata_reg;

    logic [AW-1:0]        trans_raddr, trans_waddr;
    logic [NW-1:0]        trans_wdata;
    logic                 trans_we;
    logic [NW-1:0]        len_raddr, len_waddr;
    logic signed [LW-1:0] len_wdata;
    logic                 len_we;
    logic [NW-1:0]        link_raddr, link_waddr, link_wdata;
    logic                 link_we;

    // control registers
    logic [UW-1:0]        nodes_used_reg;
    logic [TW-1:0]        total_reg;
    logic [KW-1:0]        k_reg;
    logic                 init_row_reg;
    logic [UW-1:0]        steps_reg;
    logic                 out_valid_reg;

    // payload registers
    logic [NW-1:0]        from_reg, p_reg, q_reg, r_reg, cur_reg, lnk_reg;
    logic [SW-1:0]        sym_reg;
    logic signed [LW-1:0] len_cur_reg, lenp_reg;
    logic [STATUS_W_T-1:0] err_reg;
    logic [NW-1:0]        new_node_reg;
    logic [TW-1:0]        total_out_reg;
    logic [STATUS_W_T-1:0] status_reg;

    // input checks and symbol reduction
    logic                 is_full, is_bad;
    logic [SW-1:0]        sym_red;
    logic                 steps_ok;
    logic signed [LW-1:0] lenp_inc;
    logic signed [LW:0]   diff;
    logic [TW:0]          total_sum;

    assign is_full  = ({1'b0, nodes_used_reg} + (UW+1)'(2)) > MAXN;
    assign is_bad   = {1'b0, from_node} >= nodes_used_reg;
    assign sym_red  = (symbol >= SW'(sae_pkg::ALPHABET)) ?
                      SW'(symbol - SW'(sae_pkg::ALPHABET)) : symbol;
    assign steps_ok = {1'b0, steps_reg} < MAXN;
    assign lenp_inc = lenp_reg + LW'(1);
    assign diff     = (LW+1)'(len_cur_reg) - (LW+1)'(len_rdata_reg);
    assign total_sum = {1'b0, total_reg} + (TW+1)'(diff[LW-1:0]);

    // status flags
    always_comb
    begin
        st.in_err     = is_full || is_bad;
        st.init_done  = init_row_reg && (k_reg == A_LAST);
        st.clr_done   = (k_reg == A_LAST);
        st.copy_done  = (k_reg == A_COUNT);
        st.walk_go    = (trans_rdata_reg == '0) && steps_ok;
        st.clone_go   = (trans_rdata_reg == q_reg) && steps_ok;
        st.clone_need = (len_rdata_reg != lenp_inc);
        st.out_busy   = out_valid_reg && !out_ready;
    end

    // table addresses and write data
    always_comb
    begin
        trans_raddr = {p_reg, sym_reg};
        trans_waddr = {p_reg, sym_reg};
        trans_wdata = cur_reg;
        trans_we    = 1'b0;
        len_raddr   = p_reg;
        len_waddr   = cur_reg;
        len_wdata   = len_rdata_reg + LW'(1);
        len_we      = 1'b0;
        link_raddr  = p_reg;
        link_waddr  = cur_reg;
        link_wdata  = lnk_reg;
        link_we     = 1'b0;
        case (op)
            sae_pkg::OP_INIT:
            begin
                trans_waddr = {NW'(init_row_reg), k_reg[SW-1:0]};
                trans_wdata = init_row_reg ? NW'(0) : NW'(1);
                trans_we    = 1'b1;
                len_waddr   = NW'(init_row_reg);
                len_wdata   = init_row_reg ? LW'(0) : {LW{1'b1}};
                len_we      = (k_reg == '0);
                link_waddr  = NW'(init_row_reg);
                link_wdata  = '0;
                link_we     = (k_reg == '0);
            end
            sae_pkg::OP_LEN_RD:
            begin
                len_raddr = from_reg;
            end
            sae_pkg::OP_LEN_WR:
            begin
                len_waddr = nodes_used_reg[NW-1:0];
                len_we    = 1'b1;
            end
            sae_pkg::OP_CLR:
            begin
                trans_waddr = {cur_reg, k_reg[SW-1:0]};
                trans_wdata = '0;
                trans_we    = 1'b1;
            end
            sae_pkg::OP_W_CHK:
            begin
                trans_we  = st.walk_go;
                len_raddr = p_reg;
            end
            sae_pkg::OP_LP:
            begin
                len_raddr = q_reg;
            end
            sae_pkg::OP_LQ:
            begin
                len_waddr  = nodes_used_reg[NW-1:0];
                len_wdata  = lenp_inc;
                len_we     = st.clone_need;
                link_raddr = q_reg;
            end
            sae_pkg::OP_CL_LINK:
            begin
                link_waddr = r_reg;
                link_wdata = link_rdata_reg;
                link_we    = 1'b1;
            end
            sae_pkg::OP_CL_LINK2:
            begin
                link_waddr = q_reg;
                link_wdata = r_reg;
                link_we    = 1'b1;
            end
            sae_pkg::OP_COPY:
            begin
                trans_raddr = {q_reg, k_reg[SW-1:0]};
                trans_waddr = {r_reg, SW'(k_reg - KW'(1))};
                trans_wdata = trans_rdata_reg;
                trans_we    = (k_reg != '0);
            end
            sae_pkg::OP_C_CHK:
            begin
                trans_wdata = r_reg;
                trans_we    = st.clone_go;
            end
            sae_pkg::OP_FIN:
            begin
                link_waddr = cur_reg;
                link_wdata = lnk_reg;
                link_we    = 1'b1;
                len_raddr  = lnk_reg;
            end
            default:
            begin
            end
        endcase
    end

    // memories with registered read
    always_ff @(posedge clk)
    begin
        if (trans_we)
            trans_mem[trans_waddr] <= trans_wdata;
        trans_rdata_reg <= trans_mem[trans_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[len_waddr] <= len_wdata;
        len_rdata_reg <= len_mem[len_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        link_rdata_reg <= link_mem[link_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_used_reg <= UW'(2);
            total_reg      <= '0;
            k_reg          <= '0;
            init_row_reg   <= 1'b0;
            steps_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // result register fill and drain
            if (op == sae_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (op)
                sae_pkg::OP_INIT:
                begin
                    if (k_reg == A_LAST)
                    begin
                        k_reg        <= '0;
                        init_row_reg <= 1'b1;
                    end
                    else
                        k_reg <= k_reg + KW'(1);
                end
                sae_pkg::OP_LOAD:
                    steps_reg <= '0;
                sae_pkg::OP_LEN_WR:
                begin
                    nodes_used_reg <= nodes_used_reg + UW'(1);
                    k_reg          <= '0;
                end
                sae_pkg::OP_CLR:
                    k_reg <= (k_reg == A_LAST) ? '0 : k_reg + KW'(1);
                sae_pkg::OP_W_CHK:
                    if (st.walk_go)
                        steps_reg <= steps_reg + UW'(1);
                sae_pkg::OP_LQ:
                    if (st.clone_need)
                        nodes_used_reg <= nodes_used_reg + UW'(1);
                sae_pkg::OP_CL_LINK2:
                begin
                    steps_reg <= '0;
                    k_reg     <= '0;
                end
                sae_pkg::OP_COPY:
                    k_reg <= (k_reg == A_COUNT) ? '0 : k_reg + KW'(1);
                sae_pkg::OP_C_CHK:
                    if (st.clone_go)
                        steps_reg <= steps_reg + UW'(1);
                sae_pkg::OP_DIFF:
                    if (diff > 0)
                        total_reg <= total_sum[TW] ? TOT_MAX : total_sum[TW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // walk and result payload
    always_ff @(posedge clk)
    begin
        case (op)
            sae_pkg::OP_LOAD:
            begin
                from_reg <= from_node;
                p_reg    <= from_node;
                sym_reg  <= sym_red;
                err_reg  <= is_full ? sae_pkg::ST_FULL :
                            (is_bad ? sae_pkg::ST_BAD : sae_pkg::ST_OK);
            end
            sae_pkg::OP_LEN_WR:
            begin
                cur_reg     <= nodes_used_reg[NW-1:0];
                len_cur_reg <= len_rdata_reg + LW'(1);
            end
            sae_pkg::OP_W_CHK:
                if (!st.walk_go)
                    q_reg <= trans_rdata_reg;
            sae_pkg::OP_W_LINK, sae_pkg::OP_C_LINK:
                p_reg <= link_rdata_reg;
            sae_pkg::OP_LP:
                lenp_reg <= len_rdata_reg;
            sae_pkg::OP_LQ:
            begin
                r_reg   <= nodes_used_reg[NW-1:0];
                lnk_reg <= st.clone_need ? nodes_used_reg[NW-1:0] : q_reg;
            end
            sae_pkg::OP_OUT:
            begin
                new_node_reg  <= (err_reg == sae_pkg::ST_OK) ? cur_reg : '0;
                total_out_reg <= total_reg;
                status_reg    <= err_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid           = out_valid_reg;
    assign new_node            = new_node_reg;
    assign distinct_substrings = total_out_reg;
    assign status              = status_reg;

    // node count stays within the table
    a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, nodes_used_reg} <= MAXN)
        else $error("node count beyond table size");

    // running count never goes down
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= $past(total_reg))
        else $error("substring count decreased");

    // a successful transaction always names a real node
    a_ok_node: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == sae_pkg::ST_OK) |-> new_node_reg > NW'(1))
        else $error("ok result without a new node");

endmodule
`default_nettype wire

// ===== rtl/core/suffix_automaton_extend_core.sv =====
// Suffix automaton online builder, top level.
//
// Channel req carries one transaction per symbol: from_node (node to extend
// from, root is 1, normally the node returned last) and symbol (taken modulo
// 26). Channel rsp returns one transaction per request: new_node,
// distinct_substrings (saturating running count) and status (0 ok, 1 table
// full, 2 from_node not allocated; rejected requests change nothing).
// One request is processed at a time through a sequencer that drives node
// tables with one read and one write port each. A rejected request skips
// all table work. An accepted one writes the new node's length, clears its
// transition row, walks the suffix links and sets the new node's link; a
// clone also copies a transition row and redirects transitions. The next
// request is taken in the cycle after the result is loaded.
// After reset the block initializes the sentinel and root rows with
// req.ready low. The result sits in an output register: while rsp is
// stalled the next request is still accepted and worked on, and it waits at
// the end for the register to drain.
`default_nettype none
module suffix_automaton_extend_core
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sae_in_if.sink     req,
    sae_out_if.source  rsp
);

    sae_pkg::op_t       op;
    sae_pkg::dp_status_t st;

    // sequencer
    sae_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .st       (st),
        .op       (op)
    );

    // tables and registers
    sae_dp u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .op                  (op),
        .st                  (st),
        .from_node           (req.from_node),
        .symbol              (req.symbol),
        .out_valid           (rsp.valid),
        .out_ready           (rsp.ready),
        .new_node            (rsp.new_node),
        .distinct_substrings (rsp.distinct_substrings),
        .status              (rsp.status)
    );

endmodule
`default_nettype wire
